### src/text_cell_downscale_pixel_plotter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text cell plotter
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_DOWNSCALE_PIXEL_PLOTTER_MACROS_SVH
`define TEXT_CELL_DOWNSCALE_PIXEL_PLOTTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCDPP_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tcdpp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCDPP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tcdpp assertion failed");

`endif

### src/tcdpp_pkg.sv
// ----------------------------------------------------------------------------
// tcdpp_pkg
// Types and constants shared by the text cell plotter modules.
// ----------------------------------------------------------------------------
package tcdpp_pkg;

    localparam int GLYPH_LINES      = 14;
    localparam int TEXT_COLUMNS     = 80;
    localparam int TEXT_ROWS        = 25;
    localparam int ROW_STRIDE_WORDS = 128;

    localparam int GLYPH_COUNT = 256;
    localparam int STORE_DEPTH = GLYPH_COUNT * GLYPH_LINES;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int LINE_W      = (GLYPH_LINES > 1) ? $clog2(GLYPH_LINES) : 1;
    localparam int COL_W       = (TEXT_COLUMNS > 1) ? $clog2(TEXT_COLUMNS) : 1;
    localparam int ROW_W       = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
    localparam int WADDR_W     = 16;

    typedef logic [STORE_AW-1:0] store_addr_t;
    typedef logic [LINE_W-1:0]   line_t;
    typedef logic [COL_W-1:0]    col_t;
    typedef logic [ROW_W-1:0]    row_t;
    typedef logic [WADDR_W-1:0]  word_addr_t;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_RENDER  = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] char_code;
        logic [3:0] glyph_line;
        logic [7:0] glyph_bits;
        logic [3:0] ink_color;
        logic [3:0] paper_color;
    } in_item_t;

    typedef struct packed {
        logic [15:0] word_address;
        logic [31:0] pixel_word;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        en;
        store_addr_t addr;
        logic [7:0]  data;
    } ram_wr_t;

    typedef struct packed {
        logic        en;
        store_addr_t addr;
    } ram_rd_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

endpackage

### src/tcdpp_glyph_ram.sv
// ----------------------------------------------------------------------------
// tcdpp_glyph_ram
// Glyph line store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcdpp_glyph_ram (
    input  logic                 aclk,
    input  tcdpp_pkg::ram_wr_t   wr,
    input  tcdpp_pkg::ram_rd_t   rd,
    output logic [7:0]           rd_data
);

    logic [7:0] mem [tcdpp_pkg::STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Hold read data when no read is issued.
    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

### src/text_cell_downscale_pixel_plotter.sv
// ----------------------------------------------------------------------------
// text_cell_downscale_pixel_plotter
// Path: the first line of a cell goes through the store's read register, then m_payload.
// Rate: render issues one glyph line per cycle while m_ready drains the output, bounded
// by the single read port of the glyph store; load and restart finish on acceptance.
// Reset: cell counters and handshake state clear; glyph store stays undefined.
// ----------------------------------------------------------------------------
`include "text_cell_downscale_pixel_plotter_macros.svh"

module text_cell_downscale_pixel_plotter (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tcdpp_pkg::in_item_t   s_payload,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tcdpp_pkg::out_item_t  m_payload
);

    // Expand one glyph line into four palette bytes, leftmost pair in byte 0.
    function automatic logic [31:0] pack_line(input logic [7:0] bits,
                                              input logic [3:0] fg,
                                              input logic [3:0] bg);
        logic [31:0] word;
        logic [1:0]  pair;
        logic [7:0]  pix;
        word = '0;
        for (int k = 0; k < 4; k++) begin
            pair = bits[7-2*k -: 2];
            case (pair)
                2'b00:   pix = {bg, bg};
                2'b11:   pix = {fg, fg};
                default: pix = {bg, fg};
            endcase
            word[8*k +: 8] = pix;
        end
        return word;
    endfunction

    // Sequencer state
    tcdpp_pkg::seq_state_t  state_reg, state_next;
    tcdpp_pkg::line_t       line_reg, line_next;
    tcdpp_pkg::store_addr_t rd_addr_reg, rd_addr_next;
    tcdpp_pkg::word_addr_t  waddr_reg, waddr_next;
    logic [3:0]             fg_reg, fg_next;
    logic [3:0]             bg_reg, bg_next;

    // Cell position counters
    tcdpp_pkg::col_t        col_reg, col_next;
    tcdpp_pkg::row_t        row_reg, row_next;

    // Read-in-flight stage: data sits in the store's read register
    logic                   pend_reg, pend_next;
    tcdpp_pkg::word_addr_t  pend_addr_reg, pend_addr_next;
    logic                   pend_last_reg, pend_last_next;

    // Output register
    logic                   m_valid_reg, m_valid_next;
    tcdpp_pkg::out_item_t   m_payload_reg, m_payload_next;

    tcdpp_pkg::ram_wr_t     ram_wr;
    tcdpp_pkg::ram_rd_t     ram_rd;
    logic [7:0]             ram_rdata;

    logic                   out_load;
    logic                   issue_ok;
    logic                   s_accept;
    logic                   last_line;
    logic                   run_done;
    tcdpp_pkg::store_addr_t glyph_base;
    tcdpp_pkg::word_addr_t  cell_base;
    logic [31:0]            cell_base_full;

    tcdpp_glyph_ram u_glyph_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_rdata)
    );

    // Pending data moves to the output register whenever that register frees up.
    assign out_load = pend_reg && (!m_valid_reg || m_ready);
    // A new read may overwrite the store's read register only once it is drained.
    assign issue_ok = !pend_reg || out_load;

    assign s_ready  = (state_reg == tcdpp_pkg::ST_IDLE) && issue_ok;
    assign s_accept = s_valid && s_ready;

    assign glyph_base = tcdpp_pkg::store_addr_t'(32'(s_payload.char_code)
                                                 * 32'(tcdpp_pkg::GLYPH_LINES));
    // First pixel row of the cell: row * lines * stride + column, kept to 16 bits.
    assign cell_base_full = 32'(row_reg)
                            * 32'(tcdpp_pkg::GLYPH_LINES * tcdpp_pkg::ROW_STRIDE_WORDS)
                            + 32'(col_reg);
    assign cell_base = cell_base_full[tcdpp_pkg::WADDR_W-1:0];
    assign last_line = (line_reg == tcdpp_pkg::line_t'(tcdpp_pkg::GLYPH_LINES - 1));
    // The final glyph line of the cell is issued this cycle.
    assign run_done  = (state_reg == tcdpp_pkg::ST_RUN) && issue_ok && last_line;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tcdpp_pkg::ST_IDLE;
            line_reg    <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg   <= rd_addr_next;
        waddr_reg     <= waddr_next;
        fg_reg        <= fg_next;
        bg_reg        <= bg_next;
        pend_addr_reg <= pend_addr_next;
        pend_last_reg <= pend_last_next;
        m_payload_reg <= m_payload_next;
    end

    always_comb begin
        state_next     = state_reg;
        line_next      = line_reg;
        rd_addr_next   = rd_addr_reg;
        waddr_next     = waddr_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        pend_last_next = pend_last_reg;
        m_valid_next   = m_valid_reg;
        m_payload_next = m_payload_reg;

        ram_wr.en   = 1'b0;
        ram_wr.addr = glyph_base + tcdpp_pkg::store_addr_t'(s_payload.glyph_line);
        ram_wr.data = s_payload.glyph_bits;
        ram_rd.en   = 1'b0;
        ram_rd.addr = rd_addr_reg;

        // Drain the output register, then refill it from the pending read.
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next                = 1'b1;
            m_payload_next.word_address = pend_addr_reg;
            m_payload_next.pixel_word   = pack_line(ram_rdata, fg_reg, bg_reg);
            m_payload_next.last         = pend_last_reg;
            pend_next                   = 1'b0;
        end

        case (state_reg)
            tcdpp_pkg::ST_IDLE: begin
                if (s_accept) begin
                    case (s_payload.operation)
                        tcdpp_pkg::OP_LOAD: begin
                            ram_wr.en = (32'(s_payload.glyph_line)
                                         < 32'(tcdpp_pkg::GLYPH_LINES));
                        end
                        tcdpp_pkg::OP_RESTART: begin
                            col_next = '0;
                            row_next = '0;
                        end
                        tcdpp_pkg::OP_RENDER: begin
                            // Issue glyph line 0 right away, sequence the rest.
                            ram_rd.en      = 1'b1;
                            ram_rd.addr    = glyph_base;
                            pend_next      = 1'b1;
                            pend_addr_next = cell_base;
                            pend_last_next = (tcdpp_pkg::GLYPH_LINES == 1);
                            fg_next        = s_payload.ink_color;
                            bg_next        = s_payload.paper_color;
                            rd_addr_next   = glyph_base + tcdpp_pkg::store_addr_t'(1);
                            waddr_next     = cell_base
                                + tcdpp_pkg::word_addr_t'(tcdpp_pkg::ROW_STRIDE_WORDS);
                            line_next      = tcdpp_pkg::line_t'(1);
                            if (tcdpp_pkg::GLYPH_LINES > 1) begin
                                state_next = tcdpp_pkg::ST_RUN;
                            end
                            // Advance the cell position, wrap at the screen edge.
                            if (col_reg == tcdpp_pkg::col_t'(tcdpp_pkg::TEXT_COLUMNS - 1)) begin
                                col_next = '0;
                                if (row_reg == tcdpp_pkg::row_t'(tcdpp_pkg::TEXT_ROWS - 1)) begin
                                    row_next = '0;
                                end else begin
                                    row_next = row_reg + tcdpp_pkg::row_t'(1);
                                end
                            end else begin
                                col_next = col_reg + tcdpp_pkg::col_t'(1);
                            end
                        end
                        default: begin
                            // Unused code: drop the transaction.
                        end
                    endcase
                end
            end
            tcdpp_pkg::ST_RUN: begin
                if (issue_ok) begin
                    ram_rd.en      = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = waddr_reg;
                    pend_last_next = last_line;
                    rd_addr_next   = rd_addr_reg + tcdpp_pkg::store_addr_t'(1);
                    waddr_next     = waddr_reg
                        + tcdpp_pkg::word_addr_t'(tcdpp_pkg::ROW_STRIDE_WORDS);
                    line_next      = line_reg + tcdpp_pkg::line_t'(1);
                    if (last_line) begin
                        state_next = tcdpp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = tcdpp_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Interlock: never overwrite a read that has not reached the output register.
    `TCDPP_ASSERT_NOW(a_no_read_over_pending, aclk, aresetn, pend_reg && !out_load, !ram_rd.en)
    // A stalled pending read stays pending.
    `TCDPP_ASSERT_NEXT(a_pending_held, aclk, aresetn, pend_reg && !out_load, pend_reg)
    // Issuing the last line returns the sequencer to idle.
    `TCDPP_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, run_done, state_reg == tcdpp_pkg::ST_IDLE)
    // Every issued read lands in the pending stage.
    `TCDPP_ASSERT_NEXT(a_read_pends, aclk, aresetn, ram_rd.en, pend_reg)

endmodule
